// ===== hdl/mre_pkg.sv =====
// ----------------------------------------------------------------------------
// MIPS R-type execute package
// Shared types and constants: action codes, transaction payloads, sequencer
// states and the request word of the shared adder.
// ----------------------------------------------------------------------------
package mre_pkg;

  localparam int unsigned XLen     = 32;
  localparam int unsigned RegAddrW = 5;
  localparam int unsigned NumRegs  = 32;

  localparam logic [RegAddrW-1:0] LinkReg  = 5'd31;
  localparam logic [XLen-1:0]     LinkStep = 32'd4;
  localparam logic [XLen-1:0]     SignMask = 32'h8000_0000;

  typedef enum logic [4:0] {
    ACT_ADD   = 5'd0,
    ACT_ADDU  = 5'd1,
    ACT_SUB   = 5'd2,
    ACT_SUBU  = 5'd3,
    ACT_MULT  = 5'd4,
    ACT_MULTU = 5'd5,
    ACT_DIV   = 5'd6,
    ACT_DIVU  = 5'd7,
    ACT_MFHI  = 5'd8,
    ACT_MFLO  = 5'd9,
    ACT_AND   = 5'd10,
    ACT_OR    = 5'd11,
    ACT_XOR   = 5'd12,
    ACT_NOR   = 5'd13,
    ACT_SLT   = 5'd14,
    ACT_SLTU  = 5'd15,
    ACT_SLL   = 5'd16,
    ACT_SLLV  = 5'd17,
    ACT_SRL   = 5'd18,
    ACT_SRLV  = 5'd19,
    ACT_SRA   = 5'd20,
    ACT_SRAV  = 5'd21,
    ACT_JR    = 5'd22,
    ACT_JALR  = 5'd23,
    ACT_LOAD  = 5'd24
  } action_e;

  typedef struct packed {
    logic [4:0]      action;
    logic [XLen-1:0] instruction_word;
    logic [XLen-1:0] current_pc;
    logic [XLen-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic                reg_write;
    logic [RegAddrW-1:0] reg_index;
    logic [XLen-1:0]     reg_value;
    logic [XLen-1:0]     hi_value;
    logic [XLen-1:0]     lo_value;
    logic                jump_taken;
    logic [XLen-1:0]     next_pc;
    logic                divide_by_zero;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ABS_A,
    ST_ABS_B,
    ST_MUL,
    ST_DIV,
    ST_NEG_LO,
    ST_NEG_HI,
    ST_OUT
  } state_e;

  // Request to the shared adder: x + (inv ? ~y : y) + cin, 33-bit operands
  typedef struct packed {
    logic [XLen:0] x;
    logic [XLen:0] y;
    logic          inv;
    logic          cin;
  } add_req_t;

endpackage

// ===== hdl/mre_if.sv =====
// ----------------------------------------------------------------------------
// MIPS R-type execute channels
// Valid/ready channels for the instruction transaction and the result
// transaction.
// ----------------------------------------------------------------------------
interface mre_in_if import mre_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mre_out_if import mre_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/mips_r_type_execute.sv =====
// ----------------------------------------------------------------------------
// MIPS R-type execute unit
// Executes one R-type instruction per transaction against a 32-entry
// register file and the HI/LO pair, using one shared adder under a sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                                   | Handshake
//  --------+-----+-------------------------------------------+-------------
//  in_i    | in  | action, instruction_word, current_pc,     | valid/ready
//          |     | load_value                                |
//  out_o   | out | reg_write, reg_index, reg_value, hi_value,| valid/ready
//          |     | lo_value, jump_taken, next_pc,            |
//          |     | divide_by_zero                            |
//
//  Sequence: single-pass actions pass EXEC into the output registers;
//  mult, multu, div and divu make 32 passes through the shared 33-bit adder
//  (one product or quotient bit a cycle) with sign correction before and
//  after. Divide by zero goes from ABS_A straight to the output.
//  One instruction is in flight at a time: in_i.ready is high only when idle.
//  A stalled result holds in the output registers until out_o.ready.
//  Reset clears HI, LO and the register file valid bits at once; an entry
//  never written since reset reads as zero.
//
module mips_r_type_execute import mre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mre_in_if.sink    in_i,
  mre_out_if.source out_o
);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic in_acc, out_acc;

  // decoded fields of the incoming transaction
  action_e             act_in;
  logic [RegAddrW-1:0] rs_in, rt_in;

  // captured instruction
  action_e             act_q;
  logic [RegAddrW-1:0] rd_q;
  logic [RegAddrW-1:0] sh_q;
  logic [XLen-1:0]     pc_q;
  logic [XLen-1:0]     ldv_q;

  // operands, then magnitudes for mult/div
  logic [XLen-1:0] a_q, b_q;

  // architectural HI/LO, also the working pair of the multiply/divide loop
  logic [XLen-1:0] hi_q, lo_q;
  logic [4:0]      count_q;

  logic neg_lo_q, neg_hi_q, carry_q;

  // result registers
  logic                res_wr_q;
  logic [RegAddrW-1:0] res_idx_q;
  logic [XLen-1:0]     res_val_q;
  logic                res_jmp_q;
  logic [XLen-1:0]     res_npc_q;
  logic                res_dz_q;

  // register file
  logic [XLen-1:0]    rf_mem [NumRegs];
  logic [NumRegs-1:0] rf_vld_q;
  logic               rf_we;

  // shared adder
  add_req_t        add_req;
  logic [XLen+1:0] add_sum;
  logic            div_nb;

  // single-pass execute results
  logic                ex_wr, ex_jmp;
  logic [RegAddrW-1:0] ex_idx;
  logic [XLen-1:0]     ex_val, ex_npc;
  logic [4:0]          ex_amt;
  logic                ex_less;

  logic is_signed, is_mul, is_div;

  // --------------------------------------------------------------------------
  // Handshake and decode
  // --------------------------------------------------------------------------
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign act_in = action_e'(in_i.payload.action);
  assign rs_in  = in_i.payload.instruction_word[25:21];
  assign rt_in  = in_i.payload.instruction_word[20:16];

  assign is_signed = (act_q == ACT_MULT) || (act_q == ACT_DIV);
  assign is_mul    = (act_q == ACT_MULT) || (act_q == ACT_MULTU);
  assign is_div    = (act_q == ACT_DIV) || (act_q == ACT_DIVU);

  // --------------------------------------------------------------------------
  // Shared adder: the only arithmetic unit; every add, compare, negate,
  // multiply step and divide step passes through it
  // --------------------------------------------------------------------------
  assign add_sum = {1'b0, add_req.x}
                 + {1'b0, (add_req.inv ? ~add_req.y : add_req.y)}
                 + {{(XLen+1){1'b0}}, add_req.cin};

  // no borrow on the trial subtraction of a divide step
  assign div_nb = add_sum[XLen+1];

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (act_in inside {ACT_MULT, ACT_MULTU, ACT_DIV, ACT_DIVU}) begin
            state_d = ST_ABS_A;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC:  state_d = ST_OUT;
      ST_ABS_A: begin
        // divide by zero: leave HI/LO alone and report straight away
        if (is_div && (b_q == '0)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_ABS_B;
        end
      end
      ST_ABS_B: state_d = is_mul ? ST_MUL : ST_DIV;
      ST_MUL,
      ST_DIV: begin
        if (&count_q) begin
          state_d = ST_NEG_LO;
        end
      end
      ST_NEG_LO: state_d = ST_NEG_HI;
      ST_NEG_HI: state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (handshake and adder routing)
  // --------------------------------------------------------------------------
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    out_o.valid = (state_q == ST_OUT);
    add_req     = '{x: {1'b0, a_q}, y: {1'b0, b_q}, inv: 1'b0, cin: 1'b0};
    case (state_q)
      ST_EXEC: begin
        case (act_q)
          ACT_SUB, ACT_SUBU, ACT_SLTU: begin
            add_req.inv = 1'b1;
            add_req.cin = 1'b1;
          end
          ACT_SLT: begin
            // flip the sign bits so an unsigned compare orders signed values
            add_req.x   = {1'b0, a_q ^ SignMask};
            add_req.y   = {1'b0, b_q ^ SignMask};
            add_req.inv = 1'b1;
            add_req.cin = 1'b1;
          end
          ACT_JALR: begin
            add_req.x = {1'b0, pc_q};
            add_req.y = {1'b0, LinkStep};
          end
          default: ;
        endcase
      end
      ST_ABS_A: begin
        add_req = '{x: '0, y: {1'b0, a_q}, inv: 1'b1, cin: 1'b1};
      end
      ST_ABS_B: begin
        add_req = '{x: '0, y: {1'b0, b_q}, inv: 1'b1, cin: 1'b1};
      end
      ST_MUL: begin
        add_req.x = {1'b0, hi_q};
        add_req.y = lo_q[0] ? {1'b0, a_q} : '0;
      end
      ST_DIV: begin
        add_req = '{x: {hi_q, lo_q[XLen-1]}, y: {1'b0, b_q}, inv: 1'b1, cin: 1'b1};
      end
      ST_NEG_LO: begin
        add_req = '{x: '0, y: {1'b0, lo_q}, inv: 1'b1, cin: 1'b1};
      end
      ST_NEG_HI: begin
        if (is_mul) begin
          // upper half of a 64-bit negate: ~hi plus the carry out of the low half
          add_req = '{x: {1'b0, ~hi_q}, y: '0, inv: 1'b0, cin: carry_q};
        end else begin
          add_req = '{x: '0, y: {1'b0, hi_q}, inv: 1'b1, cin: 1'b1};
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Single-pass execute
  // --------------------------------------------------------------------------
  assign ex_amt  = (act_q == ACT_SLLV || act_q == ACT_SRLV || act_q == ACT_SRAV) ?
                   a_q[4:0] : sh_q;
  assign ex_less = !add_sum[XLen+1];

  always_comb begin
    ex_wr  = 1'b0;
    ex_jmp = 1'b0;
    ex_idx = rd_q;
    ex_val = '0;
    ex_npc = '0;
    case (act_q)
      ACT_ADD, ACT_ADDU, ACT_SUB, ACT_SUBU: begin
        ex_wr  = 1'b1;
        ex_val = add_sum[XLen-1:0];
      end
      ACT_MFHI: begin ex_wr = 1'b1; ex_val = hi_q; end
      ACT_MFLO: begin ex_wr = 1'b1; ex_val = lo_q; end
      ACT_AND:  begin ex_wr = 1'b1; ex_val = a_q & b_q; end
      ACT_OR:   begin ex_wr = 1'b1; ex_val = a_q | b_q; end
      ACT_XOR:  begin ex_wr = 1'b1; ex_val = a_q ^ b_q; end
      ACT_NOR:  begin ex_wr = 1'b1; ex_val = ~(a_q | b_q); end
      ACT_SLT, ACT_SLTU: begin
        ex_wr  = 1'b1;
        ex_val = {{(XLen-1){1'b0}}, ex_less};
      end
      ACT_SLL, ACT_SLLV: begin ex_wr = 1'b1; ex_val = b_q << ex_amt; end
      ACT_SRL, ACT_SRLV: begin ex_wr = 1'b1; ex_val = b_q >> ex_amt; end
      ACT_SRA, ACT_SRAV: begin
        ex_wr  = 1'b1;
        ex_val = XLen'($signed(b_q) >>> ex_amt);
      end
      ACT_JR: begin
        ex_jmp = 1'b1;
        ex_npc = a_q;
      end
      ACT_JALR: begin
        // target is rs as read before the link write, even when rs is r31
        ex_jmp = 1'b1;
        ex_npc = a_q;
        ex_wr  = 1'b1;
        ex_idx = LinkReg;
        ex_val = add_sum[XLen-1:0];
      end
      ACT_LOAD: begin ex_wr = 1'b1; ex_val = ldv_q; end
      default: ;
    endcase
    // drop writes to r0, and report no index or value when nothing is written
    if (ex_idx == '0) begin
      ex_wr = 1'b0;
    end
    if (!ex_wr) begin
      ex_idx = '0;
      ex_val = '0;
    end
  end

  assign rf_we = (state_q == ST_EXEC) && ex_wr;

  // --------------------------------------------------------------------------
  // Register file: one write port, two registered read ports
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[ex_idx] <= ex_val;
    end
  end

  // --------------------------------------------------------------------------
  // Control state, HI/LO and loop counter
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rf_vld_q <= '0;
      hi_q     <= '0;
      lo_q     <= '0;
      count_q  <= '0;
    end else begin
      state_q <= state_d;
      if (rf_we) begin
        rf_vld_q[ex_idx] <= 1'b1;
      end
      count_q <= (state_q == ST_MUL || state_q == ST_DIV) ? count_q + 5'd1 : '0;
      case (state_q)
        ST_ABS_B: begin
          // multiplier or dividend into LO, clear the partial in HI
          hi_q <= '0;
          if (is_mul) begin
            lo_q <= (is_signed && b_q[XLen-1]) ? add_sum[XLen-1:0] : b_q;
          end else begin
            lo_q <= a_q;
          end
        end
        ST_MUL: begin
          hi_q <= add_sum[XLen:1];
          lo_q <= {add_sum[0], lo_q[XLen-1:1]};
        end
        ST_DIV: begin
          hi_q <= div_nb ? add_sum[XLen-1:0] : {hi_q[XLen-2:0], lo_q[XLen-1]};
          lo_q <= {lo_q[XLen-2:0], div_nb};
        end
        ST_NEG_LO: begin
          if (neg_lo_q) begin
            lo_q <= add_sum[XLen-1:0];
          end
        end
        ST_NEG_HI: begin
          if (neg_hi_q) begin
            hi_q <= add_sum[XLen-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          act_q     <= act_in;
          rd_q      <= in_i.payload.instruction_word[15:11];
          sh_q      <= in_i.payload.instruction_word[10:6];
          pc_q      <= in_i.payload.current_pc;
          ldv_q     <= in_i.payload.load_value;
          a_q       <= rf_vld_q[rs_in] ? rf_mem[rs_in] : '0;
          b_q       <= rf_vld_q[rt_in] ? rf_mem[rt_in] : '0;
          res_wr_q  <= 1'b0;
          res_idx_q <= '0;
          res_val_q <= '0;
          res_jmp_q <= 1'b0;
          res_npc_q <= '0;
          res_dz_q  <= 1'b0;
        end
      end
      ST_EXEC: begin
        res_wr_q  <= ex_wr;
        res_idx_q <= ex_idx;
        res_val_q <= ex_val;
        res_jmp_q <= ex_jmp;
        res_npc_q <= ex_npc;
      end
      ST_ABS_A: begin
        // sign fixes, decided on the original operands
        if (is_mul) begin
          neg_lo_q <= is_signed && (a_q[XLen-1] ^ b_q[XLen-1]);
          neg_hi_q <= is_signed && (a_q[XLen-1] ^ b_q[XLen-1]);
        end else begin
          neg_lo_q <= is_signed && (a_q[XLen-1] ^ b_q[XLen-1]);
          neg_hi_q <= is_signed && a_q[XLen-1];
        end
        if (is_signed && a_q[XLen-1]) begin
          a_q <= add_sum[XLen-1:0];
        end
        if (is_div && (b_q == '0)) begin
          res_dz_q <= 1'b1;
        end
      end
      ST_ABS_B: begin
        if (is_signed && b_q[XLen-1]) begin
          b_q <= add_sum[XLen-1:0];
        end
      end
      ST_NEG_LO: begin
        // carry into the upper half is set only when LO was zero
        carry_q <= add_sum[XLen+1];
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result transaction
  // --------------------------------------------------------------------------
  assign out_o.payload.reg_write      = res_wr_q;
  assign out_o.payload.reg_index      = res_idx_q;
  assign out_o.payload.reg_value      = res_val_q;
  assign out_o.payload.hi_value       = hi_q;
  assign out_o.payload.lo_value       = lo_q;
  assign out_o.payload.jump_taken     = res_jmp_q;
  assign out_o.payload.next_pc        = res_npc_q;
  assign out_o.payload.divide_by_zero = res_dz_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result is pending");

  a_no_r0_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.payload.reg_write && (out_o.payload.reg_index == '0)))
    else $error("result reports a write to r0");

  a_link_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.jump_taken && out_o.payload.reg_write)
      |-> (out_o.payload.reg_index == LinkReg))
    else $error("jump with a write not aimed at the link register");

  a_dz_keeps_hilo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_o.valid) && out_o.payload.divide_by_zero)
      |-> ($stable(hi_q) && $stable(lo_q) && !out_o.payload.reg_write))
    else $error("divide by zero disturbed HI/LO or wrote a register");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// MIPS R-type execute unit testbench
// Drives instruction transactions into the execute unit and checks every
// result transaction, field by field, against an in-order predictor that keeps
// its own copy of the register file and HI/LO. A short directed table comes
// first, then about 800 random instructions under three idling profiles.
// ----------------------------------------------------------------------------
module tb_top import mre_pkg::*; ();

  // Action codes 25 to 31 decode to nothing; the block must still answer.
  localparam logic [4:0] ActFirstUnused = 5'd25;
  localparam logic [4:0] ActLastUnused  = 5'd31;

  localparam int unsigned NumDirected = 31;
  localparam int unsigned NumRandom   = 800;
  // Multiply and divide are the longest actions; allow some slack after the last result.
  localparam int unsigned SettleCycles = 50;
  // Longest receiver hold-off requested, in cycles.
  localparam int unsigned HoldOffCycles = 300;
  // Cycles without any transaction on either channel before giving up.
  localparam int unsigned StallLimit = 3000;

  // One row of the directed table: instruction fields and, where the result
  // is obvious, the result typed in by hand.
  typedef struct {
    logic [4:0]  act;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] pc;
    logic [31:0] ldv;
    bit          known;
    out_item_t   res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mre_in_if  in_ch ();
  mre_out_if out_ch ();

  mips_r_type_execute dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Architectural state as the predictor sees it
  logic [XLen-1:0] arch_regs [NumRegs];
  logic [XLen-1:0] arch_hi;
  logic [XLen-1:0] arch_lo;

  // Results owed by the block, oldest first
  out_item_t   results_due [$];
  int unsigned fault_count = 0;

  // Idling profile, in percent of cycles, and a pending hold-off request
  int unsigned issue_idle_pct = 0;
  int unsigned drain_idle_pct = 0;
  int unsigned drain_hold_cycles = 0;

  // Directed table. Registers after the loads: r1 = all ones, r2 = most
  // negative, r3 = most positive. Rows marked known carry a hand-typed result.
  dir_row_t directed_rows [NumDirected] = '{
    // MFHI straight after reset reads zero
    '{ACT_MFHI,  5'd0, 5'd0, 5'd1,  5'd0,  32'h0, 32'h0, 1'b1,
      '{1'b1, 5'd1, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}},
    '{ACT_LOAD,  5'd0, 5'd0, 5'd1,  5'd0,  32'h0, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, 5'd1, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}},
    '{ACT_LOAD,  5'd0, 5'd0, 5'd2,  5'd0,  32'h0, 32'h8000_0000, 1'b1,
      '{1'b1, 5'd2, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}},
    '{ACT_LOAD,  5'd0, 5'd0, 5'd3,  5'd0,  32'h0, 32'h7FFF_FFFF, 1'b1,
      '{1'b1, 5'd3, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}},
    // Write to register zero is dropped
    '{ACT_LOAD,  5'd0, 5'd0, 5'd0,  5'd0,  32'h0, 32'hDEAD_BEEF, 1'b1,
      '{1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}},
    // Signed add and sub wrap without a trap
    '{ACT_ADD,   5'd2, 5'd1, 5'd5,  5'd0,  32'h0, 32'h0, 1'b1,
      '{1'b1, 5'd5, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}},
    '{ACT_ADDU,  5'd3, 5'd3, 5'd6,  5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_SUB,   5'd3, 5'd1, 5'd7,  5'd0,  32'h0, 32'h0, 1'b1,
      '{1'b1, 5'd7, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}},
    '{ACT_SUBU,  5'd0, 5'd1, 5'd8,  5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_MULT,  5'd2, 5'd2, 5'd0,  5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_MULTU, 5'd1, 5'd1, 5'd0,  5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_MFLO,  5'd0, 5'd0, 5'd9,  5'd0,  32'h0, 32'h0, 1'b0, '0},
    // Most negative divided by minus one
    '{ACT_DIV,   5'd2, 5'd1, 5'd0,  5'd0,  32'h0, 32'h0, 1'b1,
      '{1'b0, 5'd0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 32'h0, 1'b0}},
    // Divide by zero holds HI and LO and raises the flag
    '{ACT_DIVU,  5'd1, 5'd0, 5'd0,  5'd0,  32'h0, 32'h0, 1'b1,
      '{1'b0, 5'd0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 32'h0, 1'b1}},
    '{ACT_DIVU,  5'd1, 5'd3, 5'd0,  5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_AND,   5'd1, 5'd3, 5'd10, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_OR,    5'd2, 5'd3, 5'd11, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_XOR,   5'd1, 5'd2, 5'd12, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_NOR,   5'd0, 5'd0, 5'd13, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_SLT,   5'd2, 5'd3, 5'd14, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_SLTU,  5'd2, 5'd3, 5'd15, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_SLL,   5'd0, 5'd1, 5'd16, 5'd31, 32'h0, 32'h0, 1'b0, '0},
    // Variable shifts take the amount from the low bits of rs
    '{ACT_SLLV,  5'd1, 5'd3, 5'd17, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_SRL,   5'd0, 5'd2, 5'd18, 5'd31, 32'h0, 32'h0, 1'b0, '0},
    '{ACT_SRLV,  5'd3, 5'd1, 5'd19, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    // Arithmetic shift by zero keeps the sign
    '{ACT_SRA,   5'd0, 5'd2, 5'd20, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_SRAV,  5'd1, 5'd2, 5'd21, 5'd0,  32'h0, 32'h0, 1'b0, '0},
    '{ACT_JR,    5'd1, 5'd0, 5'd0,  5'd0,  32'h0, 32'h0, 1'b0, '0},
    // Link address wraps past the top of memory
    '{ACT_JALR,  5'd2, 5'd0, 5'd0,  5'd0,  32'hFFFF_FFFC, 32'h0, 1'b0, '0},
    // Target is the old link register, not the one being written
    '{ACT_JALR,  5'd31, 5'd0, 5'd0, 5'd0,  32'h0000_0100, 32'h0, 1'b0, '0},
    '{ActFirstUnused, 5'd1, 5'd2, 5'd3, 5'd4, 32'h0, 32'h0, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Predictor: execute one instruction on the shadow state, return the result
  // --------------------------------------------------------------------------
  function automatic out_item_t predict_execute(input in_item_t it);
    logic [4:0]         rs, rt, rd, sh;
    logic [31:0]        a, b;
    logic signed [31:0] sa, sb;
    logic signed [63:0] wide_a, wide_b;
    logic [63:0]        prod;
    out_item_t          res;

    rs = it.instruction_word[25:21];
    rt = it.instruction_word[20:16];
    rd = it.instruction_word[15:11];
    sh = it.instruction_word[10:6];
    a  = arch_regs[rs];
    b  = arch_regs[rt];
    sa = a;
    sb = b;
    wide_a = sa;
    wide_b = sb;

    res = '0;
    res.reg_index = rd;
    case (it.action)
      ACT_ADD, ACT_ADDU: begin
        res.reg_write = 1'b1;
        res.reg_value = a + b;
      end
      ACT_SUB, ACT_SUBU: begin
        res.reg_write = 1'b1;
        res.reg_value = a - b;
      end
      ACT_MULT: begin
        prod = wide_a * wide_b;
        arch_hi = prod[63:32];
        arch_lo = prod[31:0];
      end
      ACT_MULTU: begin
        prod = {32'b0, a} * {32'b0, b};
        arch_hi = prod[63:32];
        arch_lo = prod[31:0];
      end
      ACT_DIV: begin
        if (b == '0) begin
          res.divide_by_zero = 1'b1;
        end else if (a == SignMask && b == '1) begin
          // quotient does not fit: pin LO to the most negative value
          arch_lo = SignMask;
          arch_hi = '0;
        end else begin
          arch_lo = sa / sb;
          arch_hi = sa % sb;
        end
      end
      ACT_DIVU: begin
        if (b == '0) begin
          res.divide_by_zero = 1'b1;
        end else begin
          arch_lo = a / b;
          arch_hi = a % b;
        end
      end
      ACT_MFHI: begin
        res.reg_write = 1'b1;
        res.reg_value = arch_hi;
      end
      ACT_MFLO: begin
        res.reg_write = 1'b1;
        res.reg_value = arch_lo;
      end
      ACT_AND: begin
        res.reg_write = 1'b1;
        res.reg_value = a & b;
      end
      ACT_OR: begin
        res.reg_write = 1'b1;
        res.reg_value = a | b;
      end
      ACT_XOR: begin
        res.reg_write = 1'b1;
        res.reg_value = a ^ b;
      end
      ACT_NOR: begin
        res.reg_write = 1'b1;
        res.reg_value = ~(a | b);
      end
      ACT_SLT: begin
        res.reg_write = 1'b1;
        res.reg_value = {31'b0, sa < sb};
      end
      ACT_SLTU: begin
        res.reg_write = 1'b1;
        res.reg_value = {31'b0, a < b};
      end
      ACT_SLL: begin
        res.reg_write = 1'b1;
        res.reg_value = b << sh;
      end
      ACT_SLLV: begin
        res.reg_write = 1'b1;
        res.reg_value = b << a[4:0];
      end
      ACT_SRL: begin
        res.reg_write = 1'b1;
        res.reg_value = b >> sh;
      end
      ACT_SRLV: begin
        res.reg_write = 1'b1;
        res.reg_value = b >> a[4:0];
      end
      ACT_SRA: begin
        res.reg_write = 1'b1;
        res.reg_value = sb >>> sh;
      end
      ACT_SRAV: begin
        res.reg_write = 1'b1;
        res.reg_value = sb >>> a[4:0];
      end
      ACT_JR: begin
        res.jump_taken = 1'b1;
        res.next_pc    = a;
      end
      ACT_JALR: begin
        // target captured above, before the link write
        res.jump_taken = 1'b1;
        res.next_pc    = a;
        res.reg_write  = 1'b1;
        res.reg_index  = LinkReg;
        res.reg_value  = it.current_pc + LinkStep;
      end
      ACT_LOAD: begin
        res.reg_write = 1'b1;
        res.reg_value = it.load_value;
      end
      default: ;
    endcase

    // register zero is hard-wired
    if (res.reg_write && res.reg_index == '0) res.reg_write = 1'b0;
    if (res.reg_write) begin
      arch_regs[res.reg_index] = res.reg_value;
    end else begin
      res.reg_index = '0;
      res.reg_value = '0;
    end
    res.hi_value = arch_hi;
    res.lo_value = arch_lo;
    return res;
  endfunction

  // Random instruction: mostly real operations, a share of loads with values
  // chosen to hit the corner cases, and a few undecoded action codes.
  function automatic in_item_t random_instruction();
    in_item_t    it;
    int unsigned pick;

    pick = $urandom_range(99);
    it.instruction_word = $urandom();
    it.current_pc       = $urandom();
    it.load_value       = $urandom();
    if (pick < 18) begin
      it.action = ACT_LOAD;
      case ($urandom_range(5))
        0: it.load_value = '0;
        1: it.load_value = '1;
        2: it.load_value = SignMask;
        3: it.load_value = ~SignMask;
        4: it.load_value = $urandom_range(33);
        default: ;
      endcase
    end else if (pick < 23) begin
      it.action = 5'($urandom_range(ActLastUnused, ActFirstUnused));
    end else begin
      it.action = 5'($urandom_range(ACT_JALR, ACT_ADD));
    end
    return it;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
      fault_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Issue side
  // --------------------------------------------------------------------------

  // Offer one instruction, after a random idle gap, and hold it until the
  // block takes it. Valid stays high on return so back-to-back transactions
  // follow without a gap; predict at the accepting edge.
  task automatic issue_instruction(input in_item_t it, input bit known,
                                   input out_item_t typed);
    out_item_t predicted;

    if ($urandom_range(99) < issue_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < issue_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = predict_execute(it);
    results_due.push_back(known ? typed : predicted);
  endtask

  // Drop valid and hold off until every owed result has arrived. Always
  // wait for a clock edge first so valid is never re-raised in this step.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  initial begin : stimulus
    dir_row_t row;
    in_item_t item;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    arch_hi       = '0;
    arch_lo       = '0;
    arch_regs     = '{default: '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First profile: sender idles a little, receiver a lot
    issue_idle_pct = 35;
    drain_idle_pct = 55;

    for (int i = 0; i < NumDirected; i++) begin
      row  = directed_rows[i];
      item.action           = row.act;
      item.instruction_word = {6'b0, row.rs, row.rt, row.rd, row.sh, 6'b0};
      item.current_pc       = row.pc;
      item.load_value       = row.ldv;
      issue_instruction(item, row.known, row.res);
    end

    for (int n = 0; n < NumRandom; n++) begin
      // Switch idling profile only once the pipe is empty
      if (n == 270) begin
        wait_results_drained();
        issue_idle_pct = 55;
        drain_idle_pct = 35;
      end
      if (n == 540) begin
        wait_results_drained();
        issue_idle_pct = 0;
        drain_idle_pct = 0;
      end
      // Long receiver hold-off while instructions keep coming: the block
      // fills and must stall its input
      if (n == 100 || n == 400) drain_hold_cycles = HoldOffCycles;
      issue_instruction(random_instruction(), 1'b0, '0);
    end

    wait_results_drained();
    repeat (SettleCycles) @(posedge clk);

    if (fault_count == 0 && results_due.size() == 0) begin
      $display("mips_r_type_execute verification clean");
    end else begin
      $display("mips_r_type_execute verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: check each result transaction and drive ready
  // --------------------------------------------------------------------------
  initial begin : result_drain
    int unsigned hold_left;
    out_item_t   got;
    out_item_t   want;

    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (results_due.size() == 0) begin
          $error("result transaction with nothing outstanding");
          fault_count++;
        end else begin
          want = results_due.pop_front();
          compare_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
          compare_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
          compare_field("reg_value",      want.reg_value,      got.reg_value);
          compare_field("hi_value",       want.hi_value,       got.hi_value);
          compare_field("lo_value",       want.lo_value,       got.lo_value);
          compare_field("jump_taken", 32'(want.jump_taken), 32'(got.jump_taken));
          compare_field("next_pc",        want.next_pc,        got.next_pc);
          compare_field("divide_by_zero", 32'(want.divide_by_zero),
                        32'(got.divide_by_zero));
        end
      end
      // Pick up a hold-off request and count it down here
      if (drain_hold_cycles != 0) begin
        hold_left         = drain_hold_cycles;
        drain_hold_cycles = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= drain_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;

    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $error("no transaction for %0d cycles", StallLimit);
    $display("mips_r_type_execute verification failed");
    $finish;
  end

endmodule
